// ===== rtl/dwksd_pkg.sv =====
// shared constants, types and register codes for the dual wiper knob and switch decoder
// no dependencies; imported by dwksd_knob and dual_wiper_knob_and_switch_decoder
`default_nettype none

package dwksd_pkg;

  // analog sample width and internal knob accumulator width
  localparam int SAMPLE_BITS   = 12;
  localparam int POSITION_BITS = 32;

  // configuration registers
  localparam int CFG_BITS     = 12;
  localparam int CFG_IDX_BITS = 2;

  // comparison width wide enough for samples and register values
  localparam int CMP_BITS = (SAMPLE_BITS > CFG_BITS) ? SAMPLE_BITS : CFG_BITS;

  // fixed result field width of the knob position
  localparam int KNOB_BITS = 32;

  // input payload layout, lowest field first
  localparam int HALL_BITS      = 2;
  localparam int FIRST_LSB      = 0;
  localparam int SECOND_LSB     = FIRST_LSB + SAMPLE_BITS;
  localparam int ROCKER_LSB     = SECOND_LSB + SAMPLE_BITS;
  localparam int MIDDLE_LSB     = ROCKER_LSB + SAMPLE_BITS;
  localparam int THUMB_LSB      = MIDDLE_LSB + SAMPLE_BITS;
  localparam int POINTER_LSB    = THUMB_LSB + HALL_BITS;
  localparam int IN_FIELD_BITS  = POINTER_LSB + HALL_BITS;
  localparam int S_TDATA_BITS   = ((IN_FIELD_BITS + 7) / 8) * 8;

  // result payload: eight flags then the knob position
  localparam int FLAG_BITS      = 8;
  localparam int OUT_FIELD_BITS = FLAG_BITS + KNOB_BITS;
  localparam int M_TDATA_BITS   = ((OUT_FIELD_BITS + 7) / 8) * 8;

  // reset values of the registers
  localparam logic [CFG_BITS-1:0] WIPER_MIN_RST   = CFG_BITS'(500);
  localparam logic [CFG_BITS-1:0] WIPER_MAX_RST   = CFG_BITS'(2800);
  localparam logic [CFG_BITS-1:0] SWITCH_LOW_RST  = CFG_BITS'(1000);
  localparam logic [CFG_BITS-1:0] SWITCH_HIGH_RST = CFG_BITS'(2450);

  // hall bit positions, active low
  localparam int HALL_CLOSE_BIT = 0;
  localparam int HALL_OPEN_BIT  = 1;

  typedef enum logic [CFG_IDX_BITS-1:0] {
    REG_WIPER_VALID_MIN       = 2'd0,
    REG_WIPER_VALID_MAX       = 2'd1,
    REG_SWITCH_LOW_THRESHOLD  = 2'd2,
    REG_SWITCH_HIGH_THRESHOLD = 2'd3
  } cfg_index_t;

  typedef struct packed {
    logic [CFG_BITS-1:0] valid_min;
    logic [CFG_BITS-1:0] valid_max;
  } wiper_window_t;

endpackage

`default_nettype wire

// ===== rtl/dwksd_knob.sv =====
// knob tracking: wiper selection, previous samples and saturating position accumulator
// depends on dwksd_pkg
`default_nettype none

module dwksd_knob (
  input  wire logic                                    clk,
  input  wire logic                                    rst,
  input  wire logic                                    step,
  input  wire logic [dwksd_pkg::SAMPLE_BITS-1:0]       first_wiper,
  input  wire logic [dwksd_pkg::SAMPLE_BITS-1:0]       second_wiper,
  input  wire dwksd_pkg::wiper_window_t                window,
  output logic signed [dwksd_pkg::POSITION_BITS-1:0]   position_next
);

  import dwksd_pkg::*;

  localparam int DELTA_BITS = SAMPLE_BITS + 1;
  localparam int SUM_BITS   = POSITION_BITS + 1;
  localparam logic signed [POSITION_BITS-1:0] POS_MAX = {1'b0, {(POSITION_BITS-1){1'b1}}};
  localparam logic signed [POSITION_BITS-1:0] POS_MIN = {1'b1, {(POSITION_BITS-1){1'b0}}};

  logic                            use_first;
  logic                            use_first_next;
  logic                            primed;
  logic [SAMPLE_BITS-1:0]          prev_first;
  logic [SAMPLE_BITS-1:0]          prev_second;
  logic signed [POSITION_BITS-1:0] acc;

  logic [SAMPLE_BITS-1:0]          sel;
  logic                            out_of_window;
  logic signed [DELTA_BITS-1:0]    delta;
  logic signed [SUM_BITS-1:0]      sum;
  logic signed [POSITION_BITS-1:0] sat;

  always_comb begin
    sel = use_first ? first_wiper : second_wiper;
    out_of_window = (CMP_BITS'(sel) < CMP_BITS'(window.valid_min)) ||
                    (CMP_BITS'(sel) > CMP_BITS'(window.valid_max));
    use_first_next = use_first ^ out_of_window;

    // first wiper turns the other way, so its change is negated
    if (use_first_next) begin
      delta = $signed({1'b0, prev_first}) - $signed({1'b0, first_wiper});
    end else begin
      delta = $signed({1'b0, second_wiper}) - $signed({1'b0, prev_second});
    end

    sum = SUM_BITS'(acc) + SUM_BITS'(delta);
    if (sum[SUM_BITS-1] != sum[SUM_BITS-2]) begin
      sat = sum[SUM_BITS-1] ? POS_MIN : POS_MAX;
    end else begin
      sat = sum[POSITION_BITS-1:0];
    end

    // first sample only loads the previous values
    position_next = primed ? sat : acc;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      use_first   <= 1'b1;
      primed      <= 1'b0;
      prev_first  <= '0;
      prev_second <= '0;
      acc         <= '0;
    end else if (step) begin
      use_first   <= use_first_next;
      primed      <= 1'b1;
      prev_first  <= first_wiper;
      prev_second <= second_wiper;
      acc         <= position_next;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/dual_wiper_knob_and_switch_decoder.sv =====
// top level of the dual wiper knob and switch decoder: stream ports, config registers,
// switch decoding and result register; depends on dwksd_pkg and dwksd_knob
//
//  channel | direction | handshake          | payload
//  s_*     | in        | s_tvalid/s_tready  | one sample period (s_tdata)
//  m_*     | out       | m_tvalid/m_tready  | decoded switches and knob position (m_tdata)
//  cfg_*   | in        | cfg_we             | register index and value
//
// one transaction per cycle sustained while m_tready stays high; a result passes through the
// input register, then the result register
// knob state updates when the input register hands its sample to the result register
// a stalled m side holds the result; the input register still takes one more sample
// rst is synchronous; config registers return to their default values, valid flags clear
`default_nettype none

module dual_wiper_knob_and_switch_decoder (
  input  wire logic                                   clk,
  input  wire logic                                   rst,
  input  wire logic                                   s_tvalid,
  output logic                                        s_tready,
  // first_wiper, second_wiper, rocker_level, middle_level, thumb_halls, pointer_halls, zero pad
  input  wire logic [dwksd_pkg::S_TDATA_BITS-1:0]     s_tdata,
  output logic                                        m_tvalid,
  input  wire logic                                   m_tready,
  // thumb_open, thumb_close, pointer_open, pointer_close, middle_open, middle_close,
  // rocker_up, rocker_down, knob_position
  output logic [dwksd_pkg::M_TDATA_BITS-1:0]          m_tdata,
  input  wire logic                                   cfg_we,
  input  wire logic [dwksd_pkg::CFG_IDX_BITS-1:0]     cfg_index,
  input  wire logic [dwksd_pkg::CFG_BITS-1:0]         cfg_data
);

  import dwksd_pkg::*;

  logic [CFG_BITS-1:0] wiper_valid_min;
  logic [CFG_BITS-1:0] wiper_valid_max;
  logic [CFG_BITS-1:0] switch_low_threshold;
  logic [CFG_BITS-1:0] switch_high_threshold;

  logic                     in_valid;
  logic [IN_FIELD_BITS-1:0] in_data;
  logic                     advance;

  logic [SAMPLE_BITS-1:0]          first_wiper;
  logic [SAMPLE_BITS-1:0]          second_wiper;
  logic [SAMPLE_BITS-1:0]          rocker_level;
  logic [SAMPLE_BITS-1:0]          middle_level;
  logic [HALL_BITS-1:0]            thumb_halls;
  logic [HALL_BITS-1:0]            pointer_halls;
  logic                            middle_close;
  logic                            middle_open;
  logic                            rocker_up;
  logic                            rocker_down;
  logic [FLAG_BITS-1:0]            flags;
  logic signed [POSITION_BITS-1:0] position_next;
  logic signed [KNOB_BITS-1:0]     knob_position;
  wiper_window_t                   window;

  // config writes
  always_ff @(posedge clk) begin
    if (rst) begin
      wiper_valid_min       <= WIPER_MIN_RST;
      wiper_valid_max       <= WIPER_MAX_RST;
      switch_low_threshold  <= SWITCH_LOW_RST;
      switch_high_threshold <= SWITCH_HIGH_RST;
    end else if (cfg_we) begin
      unique case (cfg_index_t'(cfg_index))
        REG_WIPER_VALID_MIN:       wiper_valid_min       <= cfg_data;
        REG_WIPER_VALID_MAX:       wiper_valid_max       <= cfg_data;
        REG_SWITCH_LOW_THRESHOLD:  switch_low_threshold  <= cfg_data;
        REG_SWITCH_HIGH_THRESHOLD: switch_high_threshold <= cfg_data;
        default: ;
      endcase
    end
  end

  // input register
  assign advance  = in_valid && (!m_tvalid || m_tready);
  assign s_tready = !in_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tready) begin
      in_valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      in_data <= s_tdata[IN_FIELD_BITS-1:0];
    end
  end

  // field unpack and switch decode
  always_comb begin
    first_wiper   = in_data[FIRST_LSB   +: SAMPLE_BITS];
    second_wiper  = in_data[SECOND_LSB  +: SAMPLE_BITS];
    rocker_level  = in_data[ROCKER_LSB  +: SAMPLE_BITS];
    middle_level  = in_data[MIDDLE_LSB  +: SAMPLE_BITS];
    thumb_halls   = in_data[THUMB_LSB   +: HALL_BITS];
    pointer_halls = in_data[POINTER_LSB +: HALL_BITS];

    middle_close = CMP_BITS'(middle_level) > CMP_BITS'(switch_high_threshold);
    middle_open  = !middle_close &&
                   (CMP_BITS'(middle_level) > CMP_BITS'(switch_low_threshold));
    rocker_up    = CMP_BITS'(rocker_level) > CMP_BITS'(switch_high_threshold);
    rocker_down  = !rocker_up &&
                   (CMP_BITS'(rocker_level) > CMP_BITS'(switch_low_threshold));

    // hall bits are active low
    flags = {rocker_down, rocker_up, middle_close, middle_open,
             !pointer_halls[HALL_CLOSE_BIT], !pointer_halls[HALL_OPEN_BIT],
             !thumb_halls[HALL_CLOSE_BIT], !thumb_halls[HALL_OPEN_BIT]};

    window.valid_min = wiper_valid_min;
    window.valid_max = wiper_valid_max;

    knob_position = KNOB_BITS'(position_next);
  end

  dwksd_knob u_knob (
    .clk           (clk),
    .rst           (rst),
    .step          (advance),
    .first_wiper   (first_wiper),
    .second_wiper  (second_wiper),
    .window        (window),
    .position_next (position_next)
  );

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else begin
      m_tvalid <= advance || (m_tvalid && !m_tready);
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      m_tdata <= M_TDATA_BITS'({knob_position, flags});
    end
  end

  // a sample moved on always appears as a result next cycle
  assert property (@(posedge clk) disable iff (rst) advance |=> m_tvalid)
    else $error("result register missed a sample");

  // a held sample is kept when the result side is stalled
  assert property (@(posedge clk) disable iff (rst)
    in_valid && !advance |=> in_valid && $stable(in_data))
    else $error("input register lost a stalled sample");

  // an empty input register always takes a transaction
  assert property (@(posedge clk) disable iff (rst) !in_valid |-> s_tready)
    else $error("input register empty but not ready");

  // a result only moves on when the input register hands over
  assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready && !advance |=> $stable(m_tdata))
    else $error("result changed without a new sample");

endmodule

`default_nettype wire
